FILE: rtl/sprt_pkg.sv
`default_nettype none
package sprt_pkg;

    localparam int DEPTH   = 64;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEQ_W   = 64;
    localparam int MODE_W  = 3;
    localparam int STS_W   = 2;
    localparam int ACK_W   = 6;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [ACK_W-1:0] ACK_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ACK    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAP    = 3'd4;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL     = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_ACK,
        OP_LOOKUP,
        OP_SEARCH,
        OP_MAP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] dseq;
    } t_cmd;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [ACK_W-1:0] acked;
        logic             found;
        logic [SEQ_W-1:0] dout;
    } t_res;

    function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sprt_front.sv
`default_nettype none
module sprt_front
    import sprt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [SEQ_W-1:0]     i_seq,
    input  wire logic [SEQ_W-1:0]     i_dseq,
    output logic                      o_q_valid,
    input  wire logic                 i_q_ready,
    output t_cmd                      o_q_cmd
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    t_cmd              w_cmd;
    logic              w_push, w_pop;

    always_comb begin
        w_cmd.seq  = i_seq;
        w_cmd.dseq = i_dseq;
        case (i_mode)
            MODE_ADD:    w_cmd.op = OP_ADD;
            MODE_ACK:    w_cmd.op = OP_ACK;
            MODE_LOOKUP: w_cmd.op = OP_LOOKUP;
            MODE_SEARCH: w_cmd.op = OP_SEARCH;
            MODE_MAP:    w_cmd.op = OP_MAP;
            default:     w_cmd.op = OP_NOP;
        endcase
    end

    assign o_ready   = (r_cnt != QCNT_W'(QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_q[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_comb begin
        n_wp  = w_push ? r_wp + QPTR_W'(1) : r_wp;
        n_rp  = w_pop ? r_rp + QPTR_W'(1) : r_rp;
        n_cnt = r_cnt + QCNT_W'(w_push) - QCNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sprt_back.sv
`default_nettype none
module sprt_back
    import sprt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    output logic       o_q_ready,
    input  wire t_cmd  i_q_cmd,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_res       o_res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic [SEQ_W-1:0] r_sub_mem  [DEPTH];
    logic [SEQ_W-1:0] r_data_mem [DEPTH];
    logic [SEQ_W-1:0] r_rd_sub;
    logic [SEQ_W-1:0] r_rd_data;

    logic             r_state, n_state;
    t_op              r_op, n_op;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [PTR_W-1:0] r_idx, n_idx;
    logic [PTR_W-1:0] r_n, n_n;
    logic [ACK_W-1:0] r_acked, n_acked;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [PTR_W-1:0] r_count, n_count;
    logic [SEQ_W-1:0] r_high, n_high;
    logic             r_out_valid, n_out_valid;
    t_res             r_res, n_res;

    logic             w_out_free;
    logic             w_ld;
    logic             w_wr;
    logic [PTR_W-1:0] w_rd_addr;
    logic [ACK_W-1:0] w_acked_inc;
    t_res             w_res;

    assign w_out_free  = !r_out_valid || i_ready;
    assign o_q_ready   = (r_state == S_IDLE) && w_out_free;
    assign w_rd_addr   = (r_state == S_WALK) ? inc_ptr(r_idx) : r_head;
    assign w_acked_inc = (r_acked == ACK_MAX) ? r_acked : r_acked + ACK_W'(1);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_seq   = r_seq;
        n_idx   = r_idx;
        n_n     = r_n;
        n_acked = r_acked;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_high  = r_high;
        w_ld    = 1'b0;
        w_wr    = 1'b0;
        w_res   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    n_op    = i_q_cmd.op;
                    n_seq   = i_q_cmd.seq;
                    n_idx   = r_head;
                    n_n     = '0;
                    n_acked = '0;
                    case (i_q_cmd.op)
                        OP_ADD: begin
                            w_ld = 1'b1;
                            if (r_count == PTR_W'(DEPTH - 1)) begin
                                w_res.status = STS_FULL;
                            end else begin
                                w_wr    = 1'b1;
                                n_tail  = inc_ptr(r_tail);
                                n_count = r_count + PTR_W'(1);
                                n_high  = i_q_cmd.seq;
                            end
                        end
                        OP_ACK: begin
                            if (r_count == '0) begin
                                w_ld = 1'b1;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        OP_LOOKUP, OP_SEARCH: begin
                            if (r_count == '0) begin
                                w_ld         = 1'b1;
                                w_res.status = STS_NOTFOUND;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        OP_MAP: begin
                            w_ld        = 1'b1;
                            w_res.found = (r_high > i_q_cmd.seq);
                        end
                        default: begin
                            w_ld = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                n_idx = inc_ptr(r_idx);
                n_n   = r_n + PTR_W'(1);
                case (r_op)
                    OP_ACK: begin
                        if (r_rd_sub < r_seq) begin
                            n_head  = inc_ptr(r_head);
                            n_count = r_count - PTR_W'(1);
                            n_acked = w_acked_inc;
                            if (r_count == PTR_W'(1)) begin
                                w_ld        = 1'b1;
                                w_res.acked = w_acked_inc;
                                n_state     = S_IDLE;
                            end
                        end else begin
                            w_ld        = 1'b1;
                            w_res.acked = r_acked;
                            n_state     = S_IDLE;
                        end
                    end
                    OP_LOOKUP: begin
                        if (r_rd_sub == r_seq) begin
                            w_ld        = 1'b1;
                            w_res.found = 1'b1;
                            w_res.dout  = r_rd_data;
                            n_state     = S_IDLE;
                        end else if (r_n == r_count - PTR_W'(1)) begin
                            w_ld         = 1'b1;
                            w_res.status = STS_NOTFOUND;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_SEARCH: begin
                        if (r_rd_data == r_seq) begin
                            w_ld        = 1'b1;
                            w_res.found = 1'b1;
                            n_state     = S_IDLE;
                        end else if (r_n == r_count - PTR_W'(1)) begin
                            w_ld         = 1'b1;
                            w_res.status = STS_NOTFOUND;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        w_ld    = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = w_ld ? 1'b1 : (r_out_valid && !i_ready);
        n_res       = w_ld ? w_res : r_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_sub_mem[r_tail]  <= i_q_cmd.seq;
            r_data_mem[r_tail] <= i_q_cmd.dseq;
        end
        r_rd_sub  <= r_sub_mem[w_rd_addr];
        r_rd_data <= r_data_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_seq   <= n_seq;
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_acked <= n_acked;
        r_res   <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PTR_W'(DEPTH - 1))
        else $error("entry count beyond ring capacity");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty ring with head and tail apart");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_count != '0))
        else $error("walk on an empty ring");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld && w_res.status == STS_FULL) |=> $stable(r_count) && $stable(r_tail))
        else $error("rejected add changed the ring");

    a_out_free_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld |-> w_out_free)
        else $error("result loaded over a pending beat");

endmodule
`default_nettype wire

FILE: rtl/sent_packet_ring_tracker_unit.sv
// Sent packet ring tracker.
// Slave channel (i_s_*): one beat per operation; tuser carries mode, tdata carries
// seq (bits 63:0) and data_seq_in (bits 127:64). Master channel (o_m_*): one result
// beat per operation; tuser carries status, tdata carries acked_count, found and
// data_seq_out, zero padded to 72 bits.
// A two-beat command queue sits between the front and the execute engine, so the
// slave side keeps accepting while a result waits on the master side.
// Add, mapping query, unused modes, and ack, lookup or search on an empty ring pass
// from the queue straight into the registered result. Otherwise ack, lookup and
// search first walk the ring, visiting 1 to DEPTH-1 entries through the single read
// port of the entry memory, one entry per cycle, before their result is registered.
// The execute engine takes a new operation only while idle, never during a walk.
// Reset (i_rst_n low, synchronous) empties the ring and the queue, clears the
// highest sent number and drops any pending result beat.
// When i_m_tready stays low, the result beat holds, the engine stops before the
// next operation, the queue fills and o_s_tready drops.
`default_nettype none
module sent_packet_ring_tracker_unit
    import sprt_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,   // seq[63:0], data_seq_in[127:64]
    input  wire logic [2:0]   i_s_tuser,   // mode[2:0]
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [71:0]       o_m_tdata,   // acked_count[5:0], found[6], data_seq_out[70:7]
    output logic [1:0]        o_m_tuser    // status[1:0]
);

    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;
    t_res res;

    sprt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_mode    (i_s_tuser),
        .i_seq     (i_s_tdata[63:0]),
        .i_dseq    (i_s_tdata[127:64]),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_cmd   (q_cmd)
    );

    sprt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_cmd   (q_cmd),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_res     (res)
    );

    assign o_m_tdata = {1'b0, res.dout, res.found, res.acked};
    assign o_m_tuser = res.status;

endmodule
`default_nettype wire
